### rtl/core/hottest_sensor_fan_duty_top_assert.svh
// Assertion macros for the hottest sensor fan duty block.
`ifndef HOTTEST_SENSOR_FAN_DUTY_TOP_ASSERT_SVH
`define HOTTEST_SENSOR_FAN_DUTY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("hsfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("hsfd assertion failed");

`endif

### rtl/core/hsfd_pkg.sv
// Package with types, constants and the microcode table of the fan duty block.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

	localparam int N_SUBSYSTEMS_DEF = 4;
	localparam int IDX_IN_W = 2;
	localparam int TEMP_W = 12;
	localparam int DUTY_W = 17;
	localparam int COUNT_W = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 17;
	localparam int NUM_FAN_REGS = 4;
	localparam int DEN_W = 12;
	localparam int PROD_W = 28;
	localparam int DCNT_W = 5;

	localparam logic [DUTY_W-1:0] FULL_DUTY = 17'd65536;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_TEMP,
		REG_LOW_DUTY,
		REG_HIGH_TEMP,
		REG_HIGH_DUTY,
		REG_FAN0_MAX,
		REG_FAN1_MAX,
		REG_FAN2_MAX,
		REG_FAN3_MAX
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_SCAN,
		OP_CURVE,
		OP_PRODUCT,
		OP_DIV,
		OP_DUTY,
		OP_FAN_MUL,
		OP_FAN_OUT
	} op_t;

	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_SCAN_MORE,
		JC_CLAMPED,
		JC_DIV_MORE,
		JC_FAN_MORE
	} jc_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_SCAN,
		ST_CURVE,
		ST_PROD,
		ST_DIV,
		ST_DUTY,
		ST_FMUL,
		ST_FOUT,
		ST_END
	} step_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t target;
	} uword_t;

	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		case (s)
			ST_WAIT:  w = '{op: OP_ACCEPT,  jc: JC_NONE,      target: ST_WAIT};
			ST_SCAN:  w = '{op: OP_SCAN,    jc: JC_SCAN_MORE, target: ST_SCAN};
			ST_CURVE: w = '{op: OP_CURVE,   jc: JC_CLAMPED,   target: ST_FMUL};
			ST_PROD:  w = '{op: OP_PRODUCT, jc: JC_NONE,      target: ST_WAIT};
			ST_DIV:   w = '{op: OP_DIV,     jc: JC_DIV_MORE,  target: ST_DIV};
			ST_DUTY:  w = '{op: OP_DUTY,    jc: JC_NONE,      target: ST_WAIT};
			ST_FMUL:  w = '{op: OP_FAN_MUL, jc: JC_NONE,      target: ST_WAIT};
			ST_FOUT:  w = '{op: OP_FAN_OUT, jc: JC_FAN_MORE,  target: ST_FMUL};
			ST_END:   w = '{op: OP_NOP,     jc: JC_ALWAYS,    target: ST_WAIT};
			default:  w = '{op: OP_NOP,     jc: JC_ALWAYS,    target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/hottest_sensor_fan_duty_top.sv
// Top level of the hottest sensor fan duty block: microcoded sequencer and datapath.
// Readings are taken one at a time: a new one is accepted only after the result for the last
// fan of the previous one is loaded into the output register. When the temperature lies between
// the curve points the duty is set by the 28-step restoring divider, which is skipped when the
// curve clamps. One result per fan follows each reading, in fan order.
// Reset is asynchronous: stored temperatures go to -2048 and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module hottest_sensor_fan_duty_top #(
	parameter int N_SUBSYSTEMS = hsfd_pkg::N_SUBSYSTEMS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [hsfd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [hsfd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [hsfd_pkg::IDX_IN_W-1:0]          sensor_index,
	input  wire logic signed [hsfd_pkg::TEMP_W-1:0]     reading,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [hsfd_pkg::IDX_IN_W-1:0]               fan_index,
	output logic [hsfd_pkg::COUNT_W-1:0]                pwm_count,
	output logic [hsfd_pkg::DUTY_W-1:0]                 duty,
	output logic signed [hsfd_pkg::TEMP_W-1:0]          hottest_temp,
	output logic [hsfd_pkg::IDX_IN_W-1:0]               hottest_index,
	output logic                                        last_fan
);

	localparam int IDX_W = (N_SUBSYSTEMS > 1) ? $clog2(N_SUBSYSTEMS) : 1;
	localparam int TW = hsfd_pkg::TEMP_W;
	localparam int DW = hsfd_pkg::DUTY_W;
	localparam int CW = hsfd_pkg::COUNT_W;
	localparam int PW = hsfd_pkg::PROD_W;
	localparam int NW = hsfd_pkg::DEN_W;

	logic signed [TW-1:0] temps_q [N_SUBSYSTEMS];
	logic signed [TW-1:0] low_temp_q;
	logic signed [TW-1:0] high_temp_q;
	logic [DW-1:0]        low_duty_q;
	logic [DW-1:0]        high_duty_q;
	logic [CW-1:0]        fan_max_q [hsfd_pkg::NUM_FAN_REGS];

	hsfd_pkg::step_t      step_q;
	hsfd_pkg::step_t      step_d;
	hsfd_pkg::uword_t     uw;
	logic                 hold;
	logic                 take;
	logic                 load_out;
	logic [IDX_W-1:0]     idx_q;
	logic                 idx_last;
	logic [hsfd_pkg::DCNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	logic signed [TW-1:0] best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [DW-1:0]        ld_sat_q;
	logic [DW-1:0]        ddmag_q;
	logic                 neg_q;
	logic [NW-1:0]        dt_q;
	logic [NW-1:0]        den_q;
	logic [NW-1:0]        rem_q;
	logic [PW-1:0]        quo_q;
	logic [DW-1:0]        duty_q;
	logic [DW+CW-1:0]     prod_q;

	logic [hsfd_pkg::IDX_IN_W-1:0] fan_index_q;
	logic [CW-1:0]        pwm_count_q;
	logic [DW-1:0]        duty_out_q;
	logic signed [TW-1:0] hottest_temp_q;
	logic [hsfd_pkg::IDX_IN_W-1:0] hottest_index_q;
	logic                 last_fan_q;

	logic                 in_acc;
	logic                 wr_ok;
	logic signed [TW-1:0] cand;
	logic [DW-1:0]        ld_sat;
	logic [DW-1:0]        hd_sat;
	logic                 below;
	logic                 above;
	logic                 clamped;
	logic signed [DW:0]   dd;
	logic signed [DW:0]   dd_neg;
	logic signed [TW:0]   dt;
	logic signed [TW:0]   den;
	logic [NW:0]          trial;
	logic [NW:0]          trial_sub;
	logic                 fits;
	logic [DW:0]          duty_sum;
	logic [DW+NW-1:0]     mag_prod;

	assign cfg_ready = 1'b1;
	assign in_ready  = (uw.op == hsfd_pkg::OP_ACCEPT);
	assign in_acc    = in_valid && in_ready;
	assign wr_ok     = ({1'b0, sensor_index} < 3'(N_SUBSYSTEMS));
	assign load_out  = (uw.op == hsfd_pkg::OP_FAN_OUT) && !hold;

	assign out_valid     = out_valid_q;
	assign fan_index     = fan_index_q;
	assign pwm_count     = pwm_count_q;
	assign duty          = duty_out_q;
	assign hottest_temp  = hottest_temp_q;
	assign hottest_index = hottest_index_q;
	assign last_fan      = last_fan_q;

	assign idx_last = (idx_q == IDX_W'(N_SUBSYSTEMS - 1));
	assign cand     = temps_q[idx_q];

	assign ld_sat  = (low_duty_q > hsfd_pkg::FULL_DUTY) ? hsfd_pkg::FULL_DUTY : low_duty_q;
	assign hd_sat  = (high_duty_q > hsfd_pkg::FULL_DUTY) ? hsfd_pkg::FULL_DUTY : high_duty_q;
	assign below   = (best_q <= low_temp_q);
	assign above   = (best_q >= high_temp_q);
	assign clamped = below || above;
	assign dd      = $signed({1'b0, hd_sat}) - $signed({1'b0, ld_sat});
	assign dd_neg  = -dd;
	assign dt      = {best_q[TW-1], best_q} - {low_temp_q[TW-1], low_temp_q};
	assign den     = {high_temp_q[TW-1], high_temp_q} - {low_temp_q[TW-1], low_temp_q};

	assign mag_prod  = ddmag_q * {{(DW-NW){1'b0}}, dt_q};
	assign trial     = {rem_q, quo_q[PW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});
	assign duty_sum  = neg_q ? ({1'b0, ld_sat_q} - {1'b0, quo_q[DW-1:0]})
	                         : ({1'b0, ld_sat_q} + {1'b0, quo_q[DW-1:0]});

	always_comb begin
		uw   = hsfd_pkg::ucode_rom(step_q);
		hold = ((uw.op == hsfd_pkg::OP_ACCEPT) && !in_valid) ||
		       ((uw.op == hsfd_pkg::OP_FAN_OUT) && out_valid_q && !out_ready);
		case (uw.jc)
			hsfd_pkg::JC_NONE:      take = 1'b0;
			hsfd_pkg::JC_ALWAYS:    take = 1'b1;
			hsfd_pkg::JC_SCAN_MORE: take = !idx_last;
			hsfd_pkg::JC_CLAMPED:   take = clamped;
			hsfd_pkg::JC_DIV_MORE:  take = (div_cnt_q != '0);
			hsfd_pkg::JC_FAN_MORE:  take = !idx_last;
			default:                take = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (take) begin
			step_d = uw.target;
		end else begin
			step_d = hsfd_pkg::step_t'(step_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= hsfd_pkg::ST_WAIT;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				hsfd_pkg::OP_ACCEPT: begin
					idx_q <= '0;
				end
				hsfd_pkg::OP_SCAN: begin
					idx_q <= idx_last ? '0 : IDX_W'(idx_q + 1'b1);
				end
				hsfd_pkg::OP_PRODUCT: begin
					div_cnt_q <= hsfd_pkg::DCNT_W'(PW - 1);
				end
				hsfd_pkg::OP_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				hsfd_pkg::OP_FAN_OUT: begin
					if (!hold) begin
						idx_q <= idx_last ? '0 : IDX_W'(idx_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_SUBSYSTEMS; i++) begin
				temps_q[i] <= hsfd_pkg::TEMP_MIN;
			end
		end else if (in_acc && wr_ok) begin
			temps_q[sensor_index[IDX_W-1:0]] <= reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_temp_q  <= 12'sd480;
			low_duty_q  <= 17'd13107;
			high_temp_q <= 12'sd1280;
			high_duty_q <= 17'd65536;
			for (int i = 0; i < hsfd_pkg::NUM_FAN_REGS; i++) begin
				fan_max_q[i] <= 16'd65535;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsfd_pkg::REG_LOW_TEMP:  low_temp_q   <= $signed(cfg_data[TW-1:0]);
				hsfd_pkg::REG_LOW_DUTY:  low_duty_q   <= cfg_data[DW-1:0];
				hsfd_pkg::REG_HIGH_TEMP: high_temp_q  <= $signed(cfg_data[TW-1:0]);
				hsfd_pkg::REG_HIGH_DUTY: high_duty_q  <= cfg_data[DW-1:0];
				hsfd_pkg::REG_FAN0_MAX:  fan_max_q[0] <= cfg_data[CW-1:0];
				hsfd_pkg::REG_FAN1_MAX:  fan_max_q[1] <= cfg_data[CW-1:0];
				hsfd_pkg::REG_FAN2_MAX:  fan_max_q[2] <= cfg_data[CW-1:0];
				hsfd_pkg::REG_FAN3_MAX:  fan_max_q[3] <= cfg_data[CW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			hsfd_pkg::OP_ACCEPT: begin
				best_q     <= hsfd_pkg::TEMP_MIN;
				best_idx_q <= '0;
			end
			hsfd_pkg::OP_SCAN: begin
				if (cand > best_q) begin
					best_q     <= cand;
					best_idx_q <= idx_q;
				end
			end
			hsfd_pkg::OP_CURVE: begin
				ld_sat_q <= ld_sat;
				ddmag_q  <= dd[DW] ? dd_neg[DW-1:0] : dd[DW-1:0];
				neg_q    <= dd[DW];
				dt_q     <= dt[NW-1:0];
				den_q    <= den[NW-1:0];
				if (below) begin
					duty_q <= ld_sat;
				end else if (above) begin
					duty_q <= hd_sat;
				end
			end
			hsfd_pkg::OP_PRODUCT: begin
				quo_q <= mag_prod[PW-1:0];
				rem_q <= '0;
			end
			hsfd_pkg::OP_DIV: begin
				rem_q <= fits ? trial_sub[NW-1:0] : trial[NW-1:0];
				quo_q <= {quo_q[PW-2:0], fits};
			end
			hsfd_pkg::OP_DUTY: begin
				duty_q <= duty_sum[DW-1:0];
			end
			hsfd_pkg::OP_FAN_MUL: begin
				prod_q <= {{CW{1'b0}}, duty_q} * {{DW{1'b0}}, fan_max_q[idx_q]};
			end
			hsfd_pkg::OP_FAN_OUT: begin
				if (!hold) begin
					fan_index_q     <= hsfd_pkg::IDX_IN_W'(idx_q);
					pwm_count_q     <= prod_q[2*CW-1:CW];
					duty_out_q      <= duty_q;
					hottest_temp_q  <= best_q;
					hottest_index_q <= hsfd_pkg::IDX_IN_W'(best_idx_q);
					last_fan_q      <= idx_last;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/hsfd_checker.sv
// Port-level checker for the hottest sensor fan duty block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "hottest_sensor_fan_duty_top_assert.svh"

module hsfd_checker #(
	parameter int N_SUBSYSTEMS = hsfd_pkg::N_SUBSYSTEMS_DEF
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [hsfd_pkg::IDX_IN_W-1:0]       fan_index,
	input wire logic [hsfd_pkg::COUNT_W-1:0]        pwm_count,
	input wire logic [hsfd_pkg::DUTY_W-1:0]         duty,
	input wire logic                                last_fan
);

	// A reading keeps the block busy for at least the cycle after it is taken.
	`HSFD_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

	// The duty never exceeds full scale.
	`HSFD_ASSERT_IMP(a_duty_range, clk, arst_n, out_valid, duty <= hsfd_pkg::FULL_DUTY)

	// The last marker goes with the final fan and no other.
	`HSFD_ASSERT_IMP(a_last_fan, clk, arst_n, out_valid,
		last_fan == (fan_index == hsfd_pkg::IDX_IN_W'(N_SUBSYSTEMS - 1)))

	// A stalled result holds.
	`HSFD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pwm_count) && $stable(fan_index))

	// No new reading is taken right after a result other than the final fan's has gone.
	`HSFD_ASSERT_NXT(a_no_in_midway, clk, arst_n, out_valid && out_ready && !last_fan,
		!in_ready)

endmodule

bind hottest_sensor_fan_duty_top hsfd_checker #(.N_SUBSYSTEMS(N_SUBSYSTEMS)) u_hsfd_checker (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the hottest sensor fan duty block, with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
	import hsfd_pkg::*;

	localparam int N_FANS = N_SUBSYSTEMS_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int MAX_GAP = 60;
	localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_FAN3_MAX) + 1'b1;
	localparam logic [CFG_IDX_W-1:0] LAST_UNUSED_REG = '1;

	typedef struct {
		logic [IDX_IN_W-1:0]      fan;
		logic [COUNT_W-1:0]       pwm;
		logic [DUTY_W-1:0]        duty;
		logic signed [TEMP_W-1:0] temp;
		logic [IDX_IN_W-1:0]      hot_index;
		logic                     last;
	} fan_result_t;

	class fan_duty_tracker;
		logic signed [TEMP_W-1:0] temps [N_FANS];
		logic signed [TEMP_W-1:0] low_temp;
		logic signed [TEMP_W-1:0] high_temp;
		logic [DUTY_W-1:0]        low_duty;
		logic [DUTY_W-1:0]        high_duty;
		logic [COUNT_W-1:0]       fan_max [4];
		fan_result_t              pending_fan_results [$];
		int                       errors;
		int                       readings;
		int                       results;

		function new();
			low_temp = 12'sd480;
			low_duty = 17'd13107;
			high_temp = 12'sd1280;
			high_duty = FULL_DUTY;
			foreach (temps[i]) temps[i] = TEMP_MIN;
			foreach (fan_max[i]) fan_max[i] = 16'hFFFF;
			errors = 0;
			readings = 0;
			results = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LOW_TEMP: low_temp = data[TEMP_W-1:0];
				REG_LOW_DUTY: low_duty = data[DUTY_W-1:0];
				REG_HIGH_TEMP: high_temp = data[TEMP_W-1:0];
				REG_HIGH_DUTY: high_duty = data[DUTY_W-1:0];
				REG_FAN0_MAX, REG_FAN1_MAX, REG_FAN2_MAX, REG_FAN3_MAX:
					fan_max[idx[1:0]] = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [DUTY_W-1:0] curve_duty(logic signed [TEMP_W-1:0] t);
			longint lt;
			longint ht;
			longint ld;
			longint hd;
			longint num;
			longint den;
			lt = low_temp;
			ht = high_temp;
			ld = longint'(low_duty);
			hd = longint'(high_duty);
			if (ld > longint'(FULL_DUTY)) ld = longint'(FULL_DUTY);
			if (hd > longint'(FULL_DUTY)) hd = longint'(FULL_DUTY);
			if (longint'(t) <= lt) return ld[DUTY_W-1:0];
			if (longint'(t) >= ht) return hd[DUTY_W-1:0];
			num = (hd - ld) * (longint'(t) - lt);
			den = ht - lt;
			return DUTY_W'(ld + num / den);
		endfunction

		function void note_reading(logic [IDX_IN_W-1:0] idx, logic signed [TEMP_W-1:0] rd);
			logic signed [TEMP_W-1:0] best;
			logic [IDX_IN_W-1:0]      best_index;
			logic [DUTY_W-1:0]        d;
			fan_result_t              r;
			if (idx < N_FANS) temps[idx] = rd;
			best = temps[0];
			best_index = '0;
			for (int i = 1; i < N_FANS; i++) begin
				if (temps[i] > best) begin
					best = temps[i];
					best_index = IDX_IN_W'(i);
				end
			end
			d = curve_duty(best);
			for (int i = 0; i < N_FANS; i++) begin
				r.fan = IDX_IN_W'(i);
				r.pwm = COUNT_W'((longint'(d) * longint'(fan_max[i])) >> 16);
				r.duty = d;
				r.temp = best;
				r.hot_index = best_index;
				r.last = (i == N_FANS - 1);
				pending_fan_results.push_back(r);
			end
			readings++;
		endfunction

		function void compare_field(string name, longint expected_val, longint actual_val);
			if (expected_val != actual_val) begin
				$error("Field %s: expected %0d, got %0d", name, expected_val, actual_val);
				errors++;
			end
		endfunction

		function void check_result(fan_result_t got);
			fan_result_t want;
			results++;
			if (pending_fan_results.size() == 0) begin
				$error("Fan result for fan %0d arrived with nothing outstanding", got.fan);
				errors++;
				return;
			end
			want = pending_fan_results.pop_front();
			compare_field("fan_index", want.fan, got.fan);
			compare_field("pwm_count", want.pwm, got.pwm);
			compare_field("duty", want.duty, got.duty);
			compare_field("hottest_temp", want.temp, got.temp);
			compare_field("hottest_index", want.hot_index, got.hot_index);
			compare_field("last_fan", want.last, got.last);
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [IDX_IN_W-1:0]      sensor_index = '0;
	logic signed [TEMP_W-1:0] reading = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [IDX_IN_W-1:0]      fan_index;
	logic [COUNT_W-1:0]       pwm_count;
	logic [DUTY_W-1:0]        duty;
	logic signed [TEMP_W-1:0] hottest_temp;
	logic [IDX_IN_W-1:0]      hottest_index;
	logic                     last_fan;

	fan_duty_tracker tracker = new();
	int  stall_pct = 0;
	int  hold_left = 0;
	logic hold_start = 1'b0;
	int  cfg_writes = 0;

	hottest_sensor_fan_duty_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sensor_index(sensor_index),
		.reading(reading),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fan_index(fan_index),
		.pwm_count(pwm_count),
		.duty(duty),
		.hottest_temp(hottest_temp),
		.hottest_index(hottest_index),
		.last_fan(last_fan)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result('{fan_index, pwm_count, duty, hottest_temp, hottest_index,
				last_fan});
		if (hold_start) begin
			hold_left = LONG_HOLD_CYCLES;
			hold_start <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(idx, data);
		cfg_writes++;
	endtask

	task automatic program_curve(logic signed [TEMP_W-1:0] lt, logic [CFG_DATA_W-1:0] ld,
		logic signed [TEMP_W-1:0] ht, logic [CFG_DATA_W-1:0] hd, logic [COUNT_W-1:0] f0,
		logic [COUNT_W-1:0] f1, logic [COUNT_W-1:0] f2, logic [COUNT_W-1:0] f3);
		write_register(REG_LOW_TEMP, CFG_DATA_W'($unsigned(lt)) | (17'($urandom) & 17'h1F000));
		write_register(REG_LOW_DUTY, ld);
		write_register(REG_HIGH_TEMP, CFG_DATA_W'($unsigned(ht)));
		write_register(REG_HIGH_DUTY, hd);
		write_register(REG_FAN0_MAX, CFG_DATA_W'(f0) | (17'($urandom) & 17'h10000));
		write_register(REG_FAN1_MAX, CFG_DATA_W'(f1));
		write_register(REG_FAN2_MAX, CFG_DATA_W'(f2));
		write_register(REG_FAN3_MAX, CFG_DATA_W'(f3));
		write_register(CFG_IDX_W'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)),
			CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reading(logic [IDX_IN_W-1:0] idx, logic signed [TEMP_W-1:0] rd,
		int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_index <= idx;
		reading <= rd;
		do @(posedge clk); while (!in_ready);
		tracker.note_reading(idx, rd);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (tracker.pending_fan_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [TEMP_W-1:0] pick_reading();
		int lo;
		int hi;
		if ($urandom_range(1)) return TEMP_W'($urandom);
		lo = (tracker.low_temp < tracker.high_temp) ? tracker.low_temp : tracker.high_temp;
		hi = (tracker.low_temp < tracker.high_temp) ? tracker.high_temp : tracker.low_temp;
		lo = (lo - 64 < -2048) ? -2048 : lo - 64;
		hi = (hi + 64 > 2047) ? 2047 : hi + 64;
		return TEMP_W'(lo + int'($urandom_range(hi - lo)));
	endfunction

	task automatic run_phase(int sender_idle, int receiver_stall, int count);
		int gap;
		stall_pct = receiver_stall;
		repeat (count) begin
			gap = ($urandom_range(99) < sender_idle) ? int'($urandom_range(MAX_GAP, 1)) : 0;
			send_reading(IDX_IN_W'($urandom), pick_reading(), gap);
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset curve: ties, both clamps and the interpolation edges.
		send_reading(2'd0, -12'sd2048, 0);
		send_reading(2'd3, 12'sd2047, 0);
		send_reading(2'd1, 12'sd2047, 0);
		send_reading(2'd3, -12'sd2048, 0);
		send_reading(2'd1, 12'sd480, 0);
		send_reading(2'd1, 12'sd481, 0);
		send_reading(2'd1, 12'sd1279, 0);
		send_reading(2'd1, 12'sd1280, 0);
		send_reading(2'd2, 12'sd1279, 0);
		send_reading(2'd0, 12'sd1279, 0);
		send_reading(2'd0, -12'sd1, 0);
		send_reading(2'd1, -12'sd2048, 0);
		send_reading(2'd2, -12'sd2048, 0);
		send_reading(2'd0, -12'sd2048, 0);
		drain();

		// Equal curve points with a low duty above full scale.
		program_curve(12'sd100, 17'h1FFFF, 12'sd100, 17'd0, 16'd0, 16'd1, 16'hFFFF, 16'h8000);
		send_reading(2'd2, 12'sd100, 0);
		send_reading(2'd2, 12'sd101, 0);
		send_reading(2'd2, 12'sd99, 0);
		drain();

		// Fully crossed curve points.
		program_curve(12'sd2047, 17'd65537, -12'sd2048, 17'd12345, 16'hFFFF, 16'h5555,
			16'hAAAA, 16'd0);
		send_reading(2'd2, 12'sd2047, 0);
		send_reading(2'd2, -12'sd2048, 0);
		drain();

		// Widest possible curve.
		program_curve(-12'sd2048, 17'd0, 12'sd2047, FULL_DUTY, 16'hFFFF, 16'd1, 16'd0, 16'h8000);
		send_reading(2'd1, 12'sd0, 0);
		send_reading(2'd1, -12'sd2047, 0);
		send_reading(2'd1, 12'sd2046, 0);
		drain();

		// Back to the reset curve, then a long output hold-off to back the block up.
		program_curve(12'sd480, 17'd13107, 12'sd1280, FULL_DUTY, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF);
		hold_start <= 1'b1;
		repeat (16) send_reading(IDX_IN_W'($urandom), pick_reading(), 0);
		run_phase(0, 0, 68);

		program_curve(-12'sd600, CFG_DATA_W'($urandom_range(65536)), 12'sd900,
			CFG_DATA_W'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_phase(52, 0, 68);

		program_curve(-12'sd500, FULL_DUTY, 12'sd1500, 17'd0, 16'd0, 16'($urandom), 16'hFFFF,
			16'($urandom));
		run_phase(0, 52, 68);

		program_curve(TEMP_W'($urandom), CFG_DATA_W'($urandom), TEMP_W'($urandom),
			CFG_DATA_W'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		run_phase(26, 26, 68);

		$display("Run covered %0d sensor readings and %0d fan results with %0d register writes,",
			tracker.readings, tracker.results, cfg_writes);
		$display("across clamped, interpolated and crossed curves and four flow-control mixes.");
		if (tracker.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$error("Run did not finish in time");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
